>>> hdl/cmbp_pkg.sv
// ----------------------------------------------------------------------------
// cmbp_pkg: shared types and constants of the CoAP message byte parser
// Result item layout, result kind codes, option nibble codes and queue sizing.
// ----------------------------------------------------------------------------
package cmbp_pkg;

  // Result kinds
  typedef enum logic [2:0] {
    K_HEADER = 3'd0,
    K_TOKEN  = 3'd1,
    K_OPTHDR = 3'd2,
    K_VALUE  = 3'd3,
    K_PAYLD  = 3'd4,
    K_END    = 3'd5,
    K_ERROR  = 3'd6
  } kind_e;

  // One result item
  typedef struct packed {
    kind_e       kind;
    logic [1:0]  version;
    logic [1:0]  msg_type;
    logic [3:0]  token_len;
    logic [7:0]  code;
    logic [15:0] message_id;
    logic [15:0] option_number;
    logic [16:0] option_length;
    logic [7:0]  data_byte;
    logic        last;
  } result_t;

  // Option nibble codes and extension offsets
  localparam logic [3:0]  NIB_EXT1       = 4'd13;
  localparam logic [3:0]  NIB_EXT2       = 4'd14;
  localparam logic [3:0]  NIB_BAD        = 4'd15;
  localparam logic [16:0] EXT1_BIAS      = 17'd13;
  localparam logic [16:0] EXT2_BIAS      = 17'd269;
  localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;

  // Result queue: depth must be a power of two, at least 4
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

endpackage

>>> hdl/cmbp_in_if.sv
// ----------------------------------------------------------------------------
// cmbp_in_if: input byte channel
// valid/ready channel carrying one message byte and its end flag.
// ----------------------------------------------------------------------------
interface cmbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       end_of_message;

  modport source (output valid, output byte_value, output end_of_message, input ready);
  modport sink   (input valid, input byte_value, input end_of_message, output ready);
endinterface

>>> hdl/cmbp_out_if.sv
// ----------------------------------------------------------------------------
// cmbp_out_if: result channel
// valid/ready channel carrying one decoded result item.
// ----------------------------------------------------------------------------
interface cmbp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [1:0]  version;
  logic [1:0]  msg_type;
  logic [3:0]  token_len;
  logic [7:0]  code;
  logic [15:0] message_id;
  logic [15:0] option_number;
  logic [16:0] option_length;
  logic [7:0]  data_byte;
  logic        last;

  modport source (
    output valid, output kind, output version, output msg_type, output token_len,
    output code, output message_id, output option_number, output option_length,
    output data_byte, output last, input ready
  );
  modport sink (
    input valid, input kind, input version, input msg_type, input token_len,
    input code, input message_id, input option_number, input option_length,
    input data_byte, input last, output ready
  );
endinterface

>>> hdl/cmbp_res_fifo.sv
// ----------------------------------------------------------------------------
// cmbp_res_fifo: result queue
// Small register queue that takes up to two result items per cycle and
// hands out one per cycle on the result channel while the channel is ready.
// ----------------------------------------------------------------------------
module cmbp_res_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         push_cnt_i,
  input  cmbp_pkg::result_t  push0_i,
  input  cmbp_pkg::result_t  push1_i,
  output logic               room_o,
  cmbp_out_if.source         out_o
);
  import cmbp_pkg::*;

  result_t                mem_q [RES_DEPTH];
  logic [RES_PTR_W-1:0]   wr_q, rd_q, wr1;
  logic [RES_CNT_W-1:0]   cnt_q;
  logic                   pop;
  result_t                head;

  assign wr1    = wr_q + RES_PTR_W'(1);
  assign pop    = out_o.valid && out_o.ready;
  assign room_o = (cnt_q <= RES_CNT_W'(RES_DEPTH - 2));
  assign head   = mem_q[rd_q];

  // Storage, written at the tail one or two entries at a time
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wr_q] <= push0_i;
    if (push_cnt_i == 2'd2) mem_q[wr1]  <= push1_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + RES_PTR_W'(push_cnt_i);
      if (pop) rd_q <= rd_q + RES_PTR_W'(1);
      cnt_q <= cnt_q + RES_CNT_W'(push_cnt_i) - RES_CNT_W'(pop);
    end
  end

  // Head of queue drives the channel
  assign out_o.valid         = (cnt_q != '0);
  assign out_o.kind          = head.kind;
  assign out_o.version       = head.version;
  assign out_o.msg_type      = head.msg_type;
  assign out_o.token_len     = head.token_len;
  assign out_o.code          = head.code;
  assign out_o.message_id    = head.message_id;
  assign out_o.option_number = head.option_number;
  assign out_o.option_length = head.option_length;
  assign out_o.data_byte     = head.data_byte;
  assign out_o.last          = head.last;

endmodule

>>> hdl/coap_message_byte_parser_unit.sv
// ----------------------------------------------------------------------------
// coap_message_byte_parser_unit: CoAP message byte parser
// Decodes header, token, options and payload of a message one byte at a time.
// ----------------------------------------------------------------------------
// Takes one message byte per clock and decodes it in the same cycle against
// the parser state; its results (at most two: the byte's own result and, on
// the end-of-message byte, an end or error result) land in a 4-entry result
// queue and appear on the result channel from the next cycle on, one result
// per cycle. The input is ready whenever the queue has room for two results,
// so one byte per cycle is taken as long as the result side keeps up; the
// single result port sets the sustained rate at one result item per cycle.
// ----------------------------------------------------------------------------
module coap_message_byte_parser_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  cmbp_in_if.sink    in_i,
  cmbp_out_if.source out_o
);
  import cmbp_pkg::*;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'd0,
    PH_TOKEN   = 4'd1,
    PH_OPT     = 4'd2,
    PH_DEXT_A  = 4'd3,
    PH_DEXT_B  = 4'd4,
    PH_LEXT_A  = 4'd5,
    PH_LEXT_B  = 4'd6,
    PH_VALUE   = 4'd7,
    PH_PAYLOAD = 4'd8,
    PH_ERROR   = 4'd9
  } phase_e;

  localparam logic [1:0] HdrLastIdx = 2'd3;

  phase_e      phase_q, phase_d;
  logic [1:0]  hidx_q, hidx_d;
  logic [3:0]  tokens_q, tokens_d;
  logic [3:0]  delta_q, delta_d;
  logic [3:0]  len_q, len_d;
  logic [7:0]  ext_q, ext_d;
  logic [15:0] running_q, running_d;
  logic [16:0] vbl_q, vbl_d;
  logic [23:0] held_q, held_d;

  logic        in_fire, room;
  logic [7:0]  b;
  logic        eom;
  logic        byte_hit, end_hit, go_err, do_delta, do_len;
  logic [16:0] delta_val, len_val;
  logic [17:0] dsum;
  result_t     byte_res, end_res, res0, res1;
  logic [1:0]  push_cnt;

  assign b       = in_i.byte_value;
  assign eom     = in_i.end_of_message;
  assign in_i.ready = room;
  assign in_fire = in_i.valid && room;

  // Per-byte decode
  always_comb begin
    phase_d   = phase_q;
    hidx_d    = hidx_q;
    tokens_d  = tokens_q;
    delta_d   = delta_q;
    len_d     = len_q;
    ext_d     = ext_q;
    running_d = running_q;
    vbl_d     = vbl_q;
    held_d    = held_q;
    byte_res  = '0;
    end_res   = '0;
    byte_hit  = 1'b0;
    end_hit   = 1'b0;
    go_err    = 1'b0;
    do_delta  = 1'b0;
    do_len    = 1'b0;
    delta_val = '0;
    len_val   = '0;
    dsum      = '0;

    case (phase_q)
      PH_HEADER: begin
        if (hidx_q != HdrLastIdx) begin
          held_d = {held_q[15:0], b};
          hidx_d = hidx_q + 2'd1;
        end else begin
          byte_hit            = 1'b1;
          byte_res.kind       = K_HEADER;
          byte_res.version    = held_q[23:22];
          byte_res.msg_type   = held_q[21:20];
          byte_res.token_len  = held_q[19:16];
          byte_res.code       = held_q[15:8];
          byte_res.message_id = {held_q[7:0], b};
          tokens_d = held_q[19:16];
          hidx_d   = '0;
          held_d   = '0;
          phase_d  = (held_q[19:16] != 4'd0) ? PH_TOKEN : PH_OPT;
        end
      end
      PH_TOKEN: begin
        byte_hit           = 1'b1;
        byte_res.kind      = K_TOKEN;
        byte_res.data_byte = b;
        tokens_d = tokens_q - 4'd1;
        if (tokens_q == 4'd1) phase_d = PH_OPT;
      end
      PH_OPT: begin
        if (b == PAYLOAD_MARKER) begin
          phase_d = PH_PAYLOAD;
        end else begin
          delta_d = b[7:4];
          len_d   = b[3:0];
          if (b[7:4] == NIB_BAD || b[3:0] == NIB_BAD) begin
            go_err = 1'b1;
          end else if (b[7:4] == NIB_EXT1 || b[7:4] == NIB_EXT2) begin
            phase_d = PH_DEXT_A;
          end else begin
            do_delta  = 1'b1;
            delta_val = {13'd0, b[7:4]};
          end
        end
      end
      PH_DEXT_A: begin
        if (delta_q == NIB_EXT1) begin
          do_delta  = 1'b1;
          delta_val = {9'd0, b} + EXT1_BIAS;
        end else begin
          ext_d   = b;
          phase_d = PH_DEXT_B;
        end
      end
      PH_DEXT_B: begin
        do_delta  = 1'b1;
        delta_val = {1'b0, ext_q, b} + EXT2_BIAS;
      end
      PH_LEXT_A: begin
        if (len_q == NIB_EXT1) begin
          do_len  = 1'b1;
          len_val = {9'd0, b} + EXT1_BIAS;
        end else begin
          ext_d   = b;
          phase_d = PH_LEXT_B;
        end
      end
      PH_LEXT_B: begin
        do_len  = 1'b1;
        len_val = {1'b0, ext_q, b} + EXT2_BIAS;
      end
      PH_VALUE: begin
        byte_hit           = 1'b1;
        byte_res.kind      = K_VALUE;
        byte_res.data_byte = b;
        vbl_d = vbl_q - 17'd1;
        if (vbl_q == 17'd1) phase_d = PH_OPT;
      end
      PH_PAYLOAD: begin
        byte_hit           = 1'b1;
        byte_res.kind      = K_PAYLD;
        byte_res.data_byte = b;
      end
      default: begin
        phase_d = PH_ERROR;
      end
    endcase

    // Running option number, overflow past 16 bits is an error
    if (do_delta) begin
      dsum = {2'b00, running_q} + {1'b0, delta_val};
      if (dsum[17:16] != 2'b00) begin
        go_err = 1'b1;
      end else begin
        running_d = dsum[15:0];
        if (len_d == NIB_EXT1 || len_d == NIB_EXT2) begin
          phase_d = PH_LEXT_A;
        end else begin
          do_len  = 1'b1;
          len_val = {13'd0, len_d};
        end
      end
    end

    // Option complete: report it and move to its value bytes, if it has any
    if (do_len) begin
      byte_hit               = 1'b1;
      byte_res.kind          = K_OPTHDR;
      byte_res.option_number = running_d;
      byte_res.option_length = len_val;
      vbl_d   = len_val;
      phase_d = (len_val != 17'd0) ? PH_VALUE : PH_OPT;
    end

    if (go_err) begin
      byte_hit = 1'b1;
      byte_res = '0;
      byte_res.kind = K_ERROR;
      phase_d  = PH_ERROR;
    end

    // End of message closes it and restarts the parser
    if (eom) begin
      if (phase_d == PH_OPT || phase_d == PH_PAYLOAD) begin
        end_hit      = 1'b1;
        end_res.kind = K_END;
      end else if (phase_d != PH_ERROR) begin
        end_hit      = 1'b1;
        end_res.kind = K_ERROR;
      end
      phase_d   = PH_HEADER;
      hidx_d    = '0;
      tokens_d  = '0;
      delta_d   = '0;
      len_d     = '0;
      ext_d     = '0;
      running_d = '0;
      vbl_d     = '0;
      held_d    = '0;
    end

    end_res.last  = 1'b1;
    byte_res.last = !end_hit;
  end

  // Order the results of this byte for the queue
  always_comb begin
    res0 = byte_hit ? byte_res : end_res;
    res1 = end_res;
    push_cnt = in_fire ? ({1'b0, byte_hit} + {1'b0, end_hit}) : 2'd0;
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HEADER;
      hidx_q    <= '0;
      tokens_q  <= '0;
      delta_q   <= '0;
      len_q     <= '0;
      ext_q     <= '0;
      running_q <= '0;
      vbl_q     <= '0;
      held_q    <= '0;
    end else if (in_fire) begin
      phase_q   <= phase_d;
      hidx_q    <= hidx_d;
      tokens_q  <= tokens_d;
      delta_q   <= delta_d;
      len_q     <= len_d;
      ext_q     <= ext_d;
      running_q <= running_d;
      vbl_q     <= vbl_d;
      held_q    <= held_d;
    end
  end

  cmbp_res_fifo u_res_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .push0_i    (res0),
    .push1_i    (res1),
    .room_o     (room),
    .out_o      (out_o)
  );

`ifndef ASSERT_OFF
  // A byte that ends the message always restarts the parser
  a_eom_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && eom |=> phase_q == PH_HEADER)
    else $error("parser not back in header phase after end of message");

  // The second result of a byte can only close the message
  a_second_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_cnt == 2'd2 |-> (res1.kind == K_END || res1.kind == K_ERROR))
    else $error("second result of a byte is not an end result");

  // End and error results are always the last of their byte
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.kind == K_END || out_o.kind == K_ERROR) |-> out_o.last)
    else $error("end or error result without last flag");
`endif

endmodule
